FILE: hw/rtl/gshare_tournament_branch_predictor_core_defines.svh
// Assertion macros used by the checker file of the branch predictor.
`ifndef GSHARE_TOURNAMENT_BRANCH_PREDICTOR_CORE_DEFINES_SVH
`define GSHARE_TOURNAMENT_BRANCH_PREDICTOR_CORE_DEFINES_SVH

// Overlapping implication, checked on every rising edge outside reset.
`define GTBP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication into the following cycle.
`define GTBP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/gtbp_pkg.sv
package gtbp_pkg;

  // Width of each bit-count register and of the register address.
  localparam int unsigned CfgW     = 4;
  localparam int unsigned CfgAddrW = 4;
  localparam int unsigned DataW    = 32;

  // Counter values.
  localparam logic [1:0] WN      = 2'd1;
  localparam logic [1:0] CTR_MAX = 2'd3;

  // Register reset values.
  localparam logic [CfgW-1:0] GHB_RESET = 4'd13;
  localparam logic [CfgW-1:0] LHB_RESET = 4'd10;
  localparam logic [CfgW-1:0] PCB_RESET = 4'd10;

  typedef enum logic [1:0] {
    MODE_STATIC = 2'd0,
    MODE_GSHARE = 2'd1,
    MODE_TOURN  = 2'd2,
    MODE_OFF    = 2'd3
  } mode_e;

  typedef enum logic {
    OP_PREDICT = 1'b0,
    OP_TRAIN   = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    REG_MODE = 2'd0,
    REG_GHB  = 2'd1,
    REG_LHB  = 2'd2,
    REG_PCB  = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    CLR_ST_SWEEP = 2'b01,
    CLR_ST_READY = 2'b10
  } clr_state_e;

  typedef struct packed {
    mode_e           mode;
    logic [CfgW-1:0] ghb;
    logic [CfgW-1:0] lhb;
    logic [CfgW-1:0] pcb;
  } cfg_t;

  // Two-bit saturating counter step.
  function automatic logic [1:0] ctr_bump(logic [1:0] c, logic up);
    logic [1:0] r;
    if (up) begin
      r = (c == CTR_MAX) ? CTR_MAX : c + 2'd1;
    end else begin
      r = (c == 2'd0) ? 2'd0 : c - 2'd1;
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/gtbp_ram.sv
module gtbp_ram #(
  parameter int unsigned Width = 2,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // One write port, one registered read port; a read at the written address returns old data.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/gtbp_cfg.sv
module gtbp_cfg (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [gtbp_pkg::CfgAddrW-1:0]   paddr,
  input  logic [gtbp_pkg::DataW-1:0]      pwdata,
  output logic [gtbp_pkg::DataW-1:0]      prdata,
  output logic                            pready,
  output gtbp_pkg::cfg_t                  cfg_o
);
  import gtbp_pkg::*;

  cfg_t     cfg_q, cfg_d;
  cfg_reg_e reg_sel;
  logic     wr_en;

  assign reg_sel = cfg_reg_e'(paddr[3:2]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  // Register writes in the access phase.
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_sel)
        REG_MODE: cfg_d.mode = mode_e'(pwdata[1:0]);
        REG_GHB:  cfg_d.ghb  = pwdata[CfgW-1:0];
        REG_LHB:  cfg_d.lhb  = pwdata[CfgW-1:0];
        REG_PCB:  cfg_d.pcb  = pwdata[CfgW-1:0];
        default:  cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode <= MODE_GSHARE;
      cfg_q.ghb  <= GHB_RESET;
      cfg_q.lhb  <= LHB_RESET;
      cfg_q.pcb  <= PCB_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read-back of the selected register.
  always_comb begin
    case (reg_sel)
      REG_MODE: prdata = DataW'(cfg_q.mode);
      REG_GHB:  prdata = DataW'(cfg_q.ghb);
      REG_LHB:  prdata = DataW'(cfg_q.lhb);
      REG_PCB:  prdata = DataW'(cfg_q.pcb);
      default:  prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

FILE: hw/rtl/gtbp_clr.sv
module gtbp_clr #(
  parameter int unsigned AddrW = 13
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  output logic             busy_o,
  output logic [AddrW-1:0] addr_o
);
  import gtbp_pkg::*;

  clr_state_e       state_q, state_d;
  logic [AddrW-1:0] cnt_q, cnt_d;

  // Sweep every table address once after reset, then stay ready.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      CLR_ST_SWEEP: begin
        cnt_d = cnt_q + AddrW'(1);
        if (&cnt_q) begin
          state_d = CLR_ST_READY;
        end
      end
      CLR_ST_READY: state_d = CLR_ST_READY;
      default:      state_d = CLR_ST_SWEEP;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CLR_ST_SWEEP;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  assign busy_o = (state_q == CLR_ST_SWEEP);
  assign addr_o = cnt_q;

endmodule

FILE: hw/rtl/gshare_tournament_branch_predictor_core.sv
// Channel   Direction  Signals                                  Handshake
// request   in         op_i, branch_address_i, taken_i          start_i high, busy_o low
// result    out        predict_taken_o                          done_o, one cycle
// config    in/out     psel, penable, pwrite, paddr, pwdata,    APB, pready always high
//                      prdata
//
// One request is taken every cycle while busy_o is low; a predict request gives a
// result, a train request gives no result.
// The stages are the local history table read, then the counter table reads,
// then the result register. After reset busy_o stays high while the sweep walks
// all 2^max(GLOBAL_BITS_MAX, LOCAL_BITS_MAX, PC_INDEX_MAX) addresses (8192 by default)
// and sets all tables to their initial values. The receiver cannot stall the result.
module gshare_tournament_branch_predictor_core #(
  parameter int unsigned GLOBAL_BITS_MAX = 13,
  parameter int unsigned LOCAL_BITS_MAX  = 11,
  parameter int unsigned PC_INDEX_MAX    = 10
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic                          op_i,
  input  logic [31:0]                   branch_address_i,
  input  logic                          taken_i,
  output logic                          done_o,
  output logic                          predict_taken_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [gtbp_pkg::CfgAddrW-1:0] paddr,
  input  logic [gtbp_pkg::DataW-1:0]    pwdata,
  output logic [gtbp_pkg::DataW-1:0]    prdata,
  output logic                          pready
);
  import gtbp_pkg::*;

  localparam int unsigned GW   = GLOBAL_BITS_MAX;
  localparam int unsigned LW   = LOCAL_BITS_MAX;
  localparam int unsigned PW   = PC_INDEX_MAX;
  localparam int unsigned GLW  = (GW > LW) ? GW : LW;
  localparam int unsigned ClrW = (GLW > PW) ? GLW : PW;

  cfg_t            cfg;
  logic            clr_busy;
  logic [ClrW-1:0] clr_addr;

  logic [GW-1:0] gmask;
  logic [LW-1:0] lmask;
  logic [PW-1:0] pmask;

  logic          accept;
  op_e           in_op;
  logic [GW-1:0] gh_q, gh_d;
  logic [GW-1:0] ghist, gs_idx;
  logic [PW-1:0] lh_idx;

  // First stage: indexes and local history data.
  logic          s1_vld_q;
  op_e           s1_op_q;
  logic          s1_taken_q;
  mode_e         s1_mode_q;
  logic [GW-1:0] s1_gidx_q, s1_hidx_q;
  logic [PW-1:0] s1_lhidx_q;

  // Second stage: counter data.
  logic          s2_vld_q;
  op_e           s2_op_q;
  logic          s2_taken_q;
  mode_e         s2_mode_q;
  logic [GW-1:0] s2_gidx_q, s2_hidx_q;
  logic [LW-1:0] s2_lcidx_q;

  // Last write of each table, for reads sampled at the same edge.
  logic          fwd_lh_vld_q, fwd_gc_vld_q, fwd_cc_vld_q, fwd_lc_vld_q;
  logic [PW-1:0] fwd_lh_addr_q;
  logic [LW-1:0] fwd_lh_data_q;
  logic [GW-1:0] fwd_gc_addr_q, fwd_cc_addr_q;
  logic [LW-1:0] fwd_lc_addr_q;
  logic [1:0]    fwd_gc_data_q, fwd_cc_data_q, fwd_lc_data_q;

  logic [LW-1:0] lht_rdata, lh_old, lh_new;
  logic [LW-1:0] lc_idx;
  logic          lh_we;
  logic [1:0]    gc_rdata, cc_rdata, lc_rdata;
  logic [1:0]    gc_val, cc_val, lc_val;
  logic          gc_we, cc_we, lc_we;
  logic [1:0]    gc_wd, cc_wd, lc_wd;
  logic          global_ok, local_ok;
  logic          pred;
  logic          done_q;
  logic          pred_q;

  // Table write ports, shared between the reset sweep and training.
  logic          lht_we_p, gc_we_p, cc_we_p, lc_we_p;
  logic [PW-1:0] lht_waddr;
  logic [LW-1:0] lht_wdata;
  logic [GW-1:0] gc_waddr, cc_waddr;
  logic [LW-1:0] lc_waddr;
  logic [1:0]    gc_wdata, cc_wdata, lc_wdata;

  gtbp_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  gtbp_clr #(
    .AddrW (ClrW)
  ) u_clr (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .busy_o (clr_busy),
    .addr_o (clr_addr)
  );

  assign busy_o = clr_busy;

  // History masks: a bit count of zero acts as one, counts at or above the width cover the whole width.
  always_comb begin
    for (int i = 0; i < GW; i++) begin
      gmask[i] = (i == 0) || (32'(cfg.ghb) > i);
    end
    for (int i = 0; i < LW; i++) begin
      lmask[i] = (i == 0) || (32'(cfg.lhb) > i);
    end
    for (int i = 0; i < PW; i++) begin
      pmask[i] = (i == 0) || (32'(cfg.pcb) > i);
    end
  end

  // Request decode and table indexes.
  assign accept = start_i && !clr_busy;
  assign in_op  = op_e'(op_i);
  assign ghist  = gh_q & gmask;
  assign gs_idx = (branch_address_i[GW-1:0] & gmask) ^ ghist;
  assign lh_idx = branch_address_i[PW-1:0] & pmask;

  // Global history moves at acceptance, so the next request already sees it.
  always_comb begin
    gh_d = gh_q;
    if (accept && (in_op == OP_TRAIN)) begin
      case (cfg.mode)
        MODE_STATIC, MODE_GSHARE: gh_d = ((gh_q << 1) | GW'(taken_i)) & gmask;
        MODE_TOURN:               gh_d = (gh_q << 1) | GW'(taken_i);
        default:                  gh_d = gh_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gh_q     <= '0;
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      gh_q     <= gh_d;
      s1_vld_q <= accept;
      s2_vld_q <= s1_vld_q;
      done_q   <= s2_vld_q && (s2_op_q == OP_PREDICT);
    end
  end

  // First stage payload.
  always_ff @(posedge clk_i) begin
    s1_op_q    <= in_op;
    s1_taken_q <= taken_i;
    s1_mode_q  <= cfg.mode;
    s1_gidx_q  <= (cfg.mode == MODE_TOURN) ? ghist : gs_idx;
    s1_hidx_q  <= ghist;
    s1_lhidx_q <= lh_idx;
  end

  // Local history: update and local counter index.
  assign lh_old = (fwd_lh_vld_q && (fwd_lh_addr_q == s1_lhidx_q)) ? fwd_lh_data_q : lht_rdata;
  assign lh_new = (lh_old << 1) | LW'(s1_taken_q);
  assign lh_we  = s1_vld_q && (s1_op_q == OP_TRAIN) && (s1_mode_q == MODE_TOURN);
  assign lc_idx = lh_old & lmask;

  // Second stage payload.
  always_ff @(posedge clk_i) begin
    s2_op_q    <= s1_op_q;
    s2_taken_q <= s1_taken_q;
    s2_mode_q  <= s1_mode_q;
    s2_gidx_q  <= s1_gidx_q;
    s2_hidx_q  <= s1_hidx_q;
    s2_lcidx_q <= lc_idx;
  end

  // Counter values, corrected by a write landing at the sampling edge.
  assign gc_val = (fwd_gc_vld_q && (fwd_gc_addr_q == s2_gidx_q))  ? fwd_gc_data_q : gc_rdata;
  assign cc_val = (fwd_cc_vld_q && (fwd_cc_addr_q == s2_hidx_q))  ? fwd_cc_data_q : cc_rdata;
  assign lc_val = (fwd_lc_vld_q && (fwd_lc_addr_q == s2_lcidx_q)) ? fwd_lc_data_q : lc_rdata;

  assign global_ok = (gc_val[1] == s2_taken_q);
  assign local_ok  = (lc_val[1] == s2_taken_q);

  // Prediction and counter training.
  always_comb begin
    pred  = 1'b1;
    gc_we = 1'b0;
    cc_we = 1'b0;
    lc_we = 1'b0;
    gc_wd = ctr_bump(gc_val, s2_taken_q);
    lc_wd = ctr_bump(lc_val, s2_taken_q);
    cc_wd = ctr_bump(cc_val, global_ok);
    case (s2_mode_q)
      MODE_STATIC: begin
        pred  = 1'b1;
        gc_we = s2_op_q == OP_TRAIN;
      end
      MODE_GSHARE: begin
        pred  = gc_val[1];
        gc_we = s2_op_q == OP_TRAIN;
      end
      MODE_TOURN: begin
        pred  = cc_val[1] ? gc_val[1] : lc_val[1];
        gc_we = s2_op_q == OP_TRAIN;
        lc_we = s2_op_q == OP_TRAIN;
        cc_we = (s2_op_q == OP_TRAIN) && (global_ok != local_ok);
      end
      default: pred = 1'b1;
    endcase
    gc_we = gc_we && s2_vld_q;
    cc_we = cc_we && s2_vld_q;
    lc_we = lc_we && s2_vld_q;
  end

  // Record each training write for the following read.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_lh_vld_q <= 1'b0;
      fwd_gc_vld_q <= 1'b0;
      fwd_cc_vld_q <= 1'b0;
      fwd_lc_vld_q <= 1'b0;
    end else begin
      fwd_lh_vld_q <= lh_we;
      fwd_gc_vld_q <= gc_we;
      fwd_cc_vld_q <= cc_we;
      fwd_lc_vld_q <= lc_we;
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_lh_addr_q <= s1_lhidx_q;
    fwd_lh_data_q <= lh_new;
    fwd_gc_addr_q <= s2_gidx_q;
    fwd_gc_data_q <= gc_wd;
    fwd_cc_addr_q <= s2_hidx_q;
    fwd_cc_data_q <= cc_wd;
    fwd_lc_addr_q <= s2_lcidx_q;
    fwd_lc_data_q <= lc_wd;
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (s2_vld_q && (s2_op_q == OP_PREDICT)) begin
      pred_q <= pred;
    end
  end

  assign done_o          = done_q;
  assign predict_taken_o = pred_q;

  // Write port selection: the reset sweep writes initial values.
  assign lht_we_p  = clr_busy || lh_we;
  assign lht_waddr = clr_busy ? clr_addr[PW-1:0] : s1_lhidx_q;
  assign lht_wdata = clr_busy ? '0 : lh_new;

  assign gc_we_p  = clr_busy || gc_we;
  assign gc_waddr = clr_busy ? clr_addr[GW-1:0] : s2_gidx_q;
  assign gc_wdata = clr_busy ? WN : gc_wd;

  assign cc_we_p  = clr_busy || cc_we;
  assign cc_waddr = clr_busy ? clr_addr[GW-1:0] : s2_hidx_q;
  assign cc_wdata = clr_busy ? WN : cc_wd;

  assign lc_we_p  = clr_busy || lc_we;
  assign lc_waddr = clr_busy ? clr_addr[LW-1:0] : s2_lcidx_q;
  assign lc_wdata = clr_busy ? WN : lc_wd;

  gtbp_ram #(
    .Width (LW),
    .Depth (2 ** PW)
  ) u_lht_ram (
    .clk_i   (clk_i),
    .we_i    (lht_we_p),
    .waddr_i (lht_waddr),
    .wdata_i (lht_wdata),
    .raddr_i (lh_idx),
    .rdata_o (lht_rdata)
  );

  gtbp_ram #(
    .Width (2),
    .Depth (2 ** GW)
  ) u_gc_ram (
    .clk_i   (clk_i),
    .we_i    (gc_we_p),
    .waddr_i (gc_waddr),
    .wdata_i (gc_wdata),
    .raddr_i (s1_gidx_q),
    .rdata_o (gc_rdata)
  );

  gtbp_ram #(
    .Width (2),
    .Depth (2 ** GW)
  ) u_cc_ram (
    .clk_i   (clk_i),
    .we_i    (cc_we_p),
    .waddr_i (cc_waddr),
    .wdata_i (cc_wdata),
    .raddr_i (s1_hidx_q),
    .rdata_o (cc_rdata)
  );

  gtbp_ram #(
    .Width (2),
    .Depth (2 ** LW)
  ) u_lc_ram (
    .clk_i   (clk_i),
    .we_i    (lc_we_p),
    .waddr_i (lc_waddr),
    .wdata_i (lc_wdata),
    .raddr_i (lc_idx),
    .rdata_o (lc_rdata)
  );

endmodule

FILE: hw/rtl/gtbp_chk.sv
`include "gshare_tournament_branch_predictor_core_defines.svh"

module gtbp_chk (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          start_i,
  input logic                          busy_o,
  input logic                          op_i,
  input logic [31:0]                   branch_address_i,
  input logic                          taken_i,
  input logic                          done_o,
  input logic                          predict_taken_o,
  input logic                          psel,
  input logic                          penable,
  input logic                          pwrite,
  input logic [gtbp_pkg::CfgAddrW-1:0] paddr,
  input logic [gtbp_pkg::DataW-1:0]    pwdata,
  input logic [gtbp_pkg::DataW-1:0]    prdata,
  input logic                          pready
);
  import gtbp_pkg::*;

  logic pred_req;

  assign pred_req = start_i && !busy_o && (op_e'(op_i) == OP_PREDICT);

  // Every predict request gives a result.
  `GTBP_ASSERT_IMPL(a_pred_gives_result, clk_i, rst_ni, pred_req, ##3 done_o, "predict request without result")

  // A result only follows a predict request.
  `GTBP_ASSERT_IMPL(a_result_from_pred, clk_i, rst_ni, done_o, $past(pred_req, 3), "result without predict request")

  // Once the reset sweep has finished the block never turns busy again.
  `GTBP_ASSERT_NEXT(a_busy_stays_low, clk_i, rst_ni, !busy_o, !busy_o, "busy raised after sweep")

  // No result is shown while the tables are being swept.
  `GTBP_ASSERT_IMPL(a_no_result_in_sweep, clk_i, rst_ni, busy_o, !done_o, "result during sweep")

endmodule

bind gshare_tournament_branch_predictor_core gtbp_chk u_gtbp_chk (.*);

FILE: sim/gshare_tournament_branch_predictor_core_tb.sv
`timescale 1ns / 100ps

module gshare_tournament_branch_predictor_core_tb;
  import gtbp_pkg::*;

  localparam int unsigned GHB_MAX = 13;
  localparam int unsigned LHB_MAX = 11;
  localparam int unsigned PCB_MAX = 10;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned RAND_PHASES = 12;
  localparam int unsigned ITEMS_PER_PHASE = 160;
  localparam int unsigned POOL_SIZE = 6;

  typedef enum logic {
    ROW_REQUEST,
    ROW_WRITE
  } row_kind_e;

  // One row of the directed table: either a request or a register write.
  typedef struct {
    row_kind_e   kind;
    op_e         op;
    logic [31:0] addr;
    logic        taken;
    bit          typed;
    logic        want;
    cfg_reg_e    cfg_idx;
    logic [31:0] cfg_val;
  } stim_row_t;

  logic                clk_i;
  logic                rst_ni = 1'b0;
  logic                start_i = 1'b0;
  logic                busy_o;
  logic                op_i = 1'b0;
  logic [31:0]         branch_address_i = '0;
  logic                taken_i = 1'b0;
  logic                done_o;
  logic                predict_taken_o;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [CfgAddrW-1:0] paddr = '0;
  logic [DataW-1:0]    pwdata = '0;
  logic [DataW-1:0]    prdata;
  logic                pready;

  // Predictor state, kept in step with every accepted request.
  mode_e       cur_mode;
  logic [3:0]  ghb_cfg;
  logic [3:0]  lhb_cfg;
  logic [3:0]  pcb_cfg;
  logic [12:0] glob_hist;
  logic [1:0]  glob_ctr[1 << GHB_MAX];
  logic [1:0]  chooser_ctr[1 << GHB_MAX];
  logic [10:0] loc_hist[1 << PCB_MAX];
  logic [1:0]  loc_ctr[1 << LHB_MAX];

  logic        expected_predictions[$];
  int unsigned mismatch_count = 0;
  stim_row_t   directed_rows[$];

  gshare_tournament_branch_predictor_core i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .op_i             (op_i),
    .branch_address_i (branch_address_i),
    .taken_i          (taken_i),
    .done_o           (done_o),
    .predict_taken_o  (predict_taken_o),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Safety net against a hung handshake.
  initial begin
    #3_000_000;
    $display("Verification failed");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  // A bit-count register of zero counts as one, anything past the maximum as the maximum.
  function automatic logic [31:0] field_mask(input logic [3:0] r, input int unsigned maxb);
    int unsigned b;
    b = 32'(r);
    if (b < 1) b = 1;
    if (b > maxb) b = maxb;
    return (32'd1 << b) - 32'd1;
  endfunction

  function automatic logic [1:0] sat_step(input logic [1:0] c, input logic up);
    if (up) return (c == CTR_MAX) ? c : c + 2'd1;
    return (c == 2'd0) ? c : c - 2'd1;
  endfunction

  // Table indices derived from the address and the current histories.
  function automatic void lookup_indices(input logic [31:0] addr, output logic [12:0] gmask,
                                         output logic [12:0] ghist, output logic [12:0] gs_idx,
                                         output logic [9:0] lh_idx, output logic [10:0] lc_idx);
    logic [31:0] gmask_w;
    logic [31:0] lmask;
    logic [31:0] pmask;
    gmask_w = field_mask(ghb_cfg, GHB_MAX);
    lmask   = field_mask(lhb_cfg, LHB_MAX);
    pmask   = field_mask(pcb_cfg, PCB_MAX);
    gmask   = gmask_w[12:0];
    ghist   = glob_hist & gmask;
    gs_idx  = (addr[12:0] & gmask) ^ ghist;
    lh_idx  = addr[9:0] & pmask[9:0];
    lc_idx  = loc_hist[lh_idx] & lmask[10:0];
  endfunction

  function automatic logic predict_direction(input logic [31:0] addr);
    logic [12:0] gmask, ghist, gs_idx;
    logic [9:0]  lh_idx;
    logic [10:0] lc_idx;
    logic        pred;
    lookup_indices(addr, gmask, ghist, gs_idx, lh_idx, lc_idx);
    pred = 1'b1;
    case (cur_mode)
      MODE_GSHARE: begin
        pred = glob_ctr[gs_idx][1];
      end
      MODE_TOURN: begin
        // The chooser's upper half prefers the global side.
        pred = chooser_ctr[ghist][1] ? glob_ctr[ghist][1] : loc_ctr[lc_idx][1];
      end
      default: begin
      end
    endcase
    return pred;
  endfunction

  function automatic void train_tables(input logic [31:0] addr, input logic tk);
    logic [12:0] gmask, ghist, gs_idx;
    logic [9:0]  lh_idx;
    logic [10:0] lc_idx;
    logic        local_ok, global_ok;
    lookup_indices(addr, gmask, ghist, gs_idx, lh_idx, lc_idx);
    case (cur_mode)
      // Static mode trains the gshare tables as well.
      MODE_STATIC, MODE_GSHARE: begin
        glob_ctr[gs_idx] = sat_step(glob_ctr[gs_idx], tk);
        glob_hist = {glob_hist[11:0], tk} & gmask;
      end
      MODE_TOURN: begin
        local_ok  = (loc_ctr[lc_idx][1] == tk);
        global_ok = (glob_ctr[ghist][1] == tk);
        loc_ctr[lc_idx]  = sat_step(loc_ctr[lc_idx], tk);
        loc_hist[lh_idx] = {loc_hist[lh_idx][9:0], tk};
        glob_ctr[ghist]  = sat_step(glob_ctr[ghist], tk);
        glob_hist        = {glob_hist[11:0], tk};
        if (global_ok && !local_ok) begin
          chooser_ctr[ghist] = sat_step(chooser_ctr[ghist], 1'b1);
        end else if (!global_ok && local_ok) begin
          chooser_ctr[ghist] = sat_step(chooser_ctr[ghist], 1'b0);
        end
      end
      default: begin
      end
    endcase
  endfunction

  function automatic stim_row_t req_row(input op_e op, input logic [31:0] addr, input logic tk,
                                        input bit typed = 1'b0, input logic want = 1'b0);
    stim_row_t r;
    r = '{kind: ROW_REQUEST, op: op, addr: addr, taken: tk, typed: typed, want: want,
          cfg_idx: REG_MODE, cfg_val: '0};
    return r;
  endfunction

  function automatic stim_row_t cfg_row(input cfg_reg_e idx, input logic [31:0] val);
    stim_row_t r;
    r = '{kind: ROW_WRITE, op: OP_PREDICT, addr: '0, taken: 1'b0, typed: 1'b0, want: 1'b0,
          cfg_idx: idx, cfg_val: val};
    return r;
  endfunction

  // Present one request and hold it until the block takes it.
  task automatic issue_request(input op_e op, input logic [31:0] addr, input logic tk,
                               input bit typed = 1'b0, input logic want = 1'b0);
    start_i          <= 1'b1;
    op_i             <= op;
    branch_address_i <= addr;
    taken_i          <= tk;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    if (op == OP_PREDICT) begin
      expected_predictions.push_back(typed ? want : predict_direction(addr));
    end else begin
      train_tables(addr, tk);
    end
  endtask

  task automatic idle_burst();
    start_i <= 1'b0;
    repeat ($urandom_range(1, 13)) @(posedge clk_i);
  endtask

  // Let every outstanding request leave the pipeline, trains included.
  task automatic drain_pipeline();
    start_i <= 1'b0;
    while (expected_predictions.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic apb_write(input cfg_reg_e idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    case (idx)
      REG_MODE: cur_mode = mode_e'(val[1:0]);
      REG_GHB:  ghb_cfg  = val[3:0];
      REG_LHB:  lhb_cfg  = val[3:0];
      REG_PCB:  pcb_cfg  = val[3:0];
      default: begin
      end
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // Each prediction leaving the block is matched against the oldest one expected.
  always @(posedge clk_i) begin
    logic want;
    if (rst_ni && done_o === 1'b1) begin
      if (expected_predictions.size() == 0) begin
        report_mismatch($sformatf("prediction %b with none expected", predict_taken_o));
      end else begin
        want = expected_predictions.pop_front();
        if (predict_taken_o !== want) begin
          report_mismatch($sformatf("predict_taken %b, expected %b", predict_taken_o, want));
        end
      end
    end
  end

  initial begin
    logic [31:0] pool_addr[POOL_SIZE];
    logic [7:0]  pool_pat[POOL_SIZE];
    int unsigned pool_len[POOL_SIZE];
    int unsigned pool_cnt[POOL_SIZE];
    int unsigned idle_pct, r, k, guard;
    logic [3:0]  bits[3];
    mode_e       mode;
    logic        tk;

    // State after reset.
    cur_mode  = MODE_GSHARE;
    ghb_cfg   = GHB_RESET;
    lhb_cfg   = LHB_RESET;
    pcb_cfg   = PCB_RESET;
    glob_hist = '0;
    foreach (glob_ctr[i]) glob_ctr[i] = WN;
    foreach (chooser_ctr[i]) chooser_ctr[i] = WN;
    foreach (loc_hist[i]) loc_hist[i] = '0;
    foreach (loc_ctr[i]) loc_ctr[i] = WN;

    // Directed part: extremes of the address, every scheme, out-of-range bit counts.
    directed_rows.push_back(req_row(OP_PREDICT, 32'h0000_0000, 1'b0, 1'b1, 1'b0));
    directed_rows.push_back(req_row(OP_PREDICT, 32'hFFFF_FFFF, 1'b0, 1'b1, 1'b0));
    directed_rows.push_back(req_row(OP_TRAIN, 32'hFFFF_FFFF, 1'b1));
    directed_rows.push_back(req_row(OP_TRAIN, 32'hFFFF_FFFF, 1'b1));
    directed_rows.push_back(req_row(OP_TRAIN, 32'h0000_0000, 1'b0));
    directed_rows.push_back(req_row(OP_PREDICT, 32'hFFFF_FFFF, 1'b0));
    directed_rows.push_back(cfg_row(REG_MODE, 32'(MODE_STATIC)));
    directed_rows.push_back(req_row(OP_PREDICT, 32'h1234_5678, 1'b0, 1'b1, 1'b1));
    directed_rows.push_back(req_row(OP_TRAIN, 32'hA5A5_A5A5, 1'b1));
    directed_rows.push_back(cfg_row(REG_MODE, 32'(MODE_OFF)));
    directed_rows.push_back(req_row(OP_PREDICT, 32'h5A5A_5A5A, 1'b0, 1'b1, 1'b1));
    directed_rows.push_back(req_row(OP_TRAIN, 32'h5A5A_5A5A, 1'b0));
    directed_rows.push_back(cfg_row(REG_MODE, 32'(MODE_GSHARE)));
    directed_rows.push_back(req_row(OP_PREDICT, 32'hA5A5_A5A5, 1'b0));
    directed_rows.push_back(cfg_row(REG_MODE, 32'(MODE_TOURN)));
    directed_rows.push_back(req_row(OP_TRAIN, 32'h0000_0400, 1'b1));
    directed_rows.push_back(req_row(OP_TRAIN, 32'h0000_0400, 1'b1));
    directed_rows.push_back(req_row(OP_PREDICT, 32'h0000_0400, 1'b0));
    directed_rows.push_back(cfg_row(REG_GHB, 32'd0));
    directed_rows.push_back(cfg_row(REG_LHB, 32'd0));
    directed_rows.push_back(cfg_row(REG_PCB, 32'd0));
    directed_rows.push_back(req_row(OP_TRAIN, 32'hFFFF_FFFF, 1'b0));
    directed_rows.push_back(req_row(OP_PREDICT, 32'hFFFF_FFFF, 1'b0));
    directed_rows.push_back(cfg_row(REG_GHB, 32'd15));
    directed_rows.push_back(cfg_row(REG_LHB, 32'd15));
    directed_rows.push_back(cfg_row(REG_PCB, 32'd15));
    directed_rows.push_back(req_row(OP_TRAIN, 32'h8000_0001, 1'b1));
    directed_rows.push_back(req_row(OP_PREDICT, 32'h8000_0001, 1'b0));
    directed_rows.push_back(cfg_row(REG_MODE, 32'(MODE_GSHARE)));
    directed_rows.push_back(cfg_row(REG_GHB, 32'd1));
    directed_rows.push_back(req_row(OP_TRAIN, 32'h7FFF_FFFE, 1'b1));
    directed_rows.push_back(req_row(OP_PREDICT, 32'h7FFF_FFFE, 1'b0));

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_WRITE) begin
        drain_pipeline();
        apb_write(directed_rows[i].cfg_idx, directed_rows[i].cfg_val);
      end else begin
        issue_request(directed_rows[i].op, directed_rows[i].addr, directed_rows[i].taken,
                      directed_rows[i].typed, directed_rows[i].want);
      end
    end

    // Random part: one register setting per phase, extremes in the early phases.
    for (int p = 0; p < RAND_PHASES; p++) begin
      if (p < 4) begin
        mode = mode_e'(p);
      end else if (p < 8) begin
        mode = (p % 2 == 0) ? MODE_TOURN : MODE_GSHARE;
      end else begin
        r = $urandom_range(0, 9);
        mode = (r < 5) ? MODE_TOURN : (r < 8) ? MODE_GSHARE : (r == 8) ? MODE_STATIC : MODE_OFF;
      end
      foreach (bits[j]) begin
        case (p)
          4:       bits[j] = 4'd0;
          5:       bits[j] = 4'd15;
          6:       bits[j] = 4'd1;
          default: bits[j] = 4'($urandom_range(0, 15));
        endcase
      end
      if (p == 7) begin
        bits[0] = 4'(GHB_MAX);
        bits[1] = 4'(LHB_MAX);
        bits[2] = 4'(PCB_MAX);
      end
      drain_pipeline();
      apb_write(REG_MODE, 32'(mode));
      apb_write(REG_GHB, 32'(bits[0]));
      apb_write(REG_LHB, 32'(bits[1]));
      apb_write(REG_PCB, 32'(bits[2]));

      // A few branches with repeating outcome patterns, so that the tables learn.
      for (int j = 0; j < POOL_SIZE; j++) begin
        pool_addr[j] = $urandom;
        pool_pat[j]  = 8'($urandom);
        pool_len[j]  = $urandom_range(1, 8);
        pool_cnt[j]  = 0;
      end
      r = $urandom_range(0, 2);
      idle_pct = (p == RAND_PHASES - 1) ? 0 : (r == 0) ? 0 : (r == 1) ? 10 : 30;

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        r = $urandom_range(0, 99);
        k = $urandom_range(0, POOL_SIZE - 1);
        if (r < 55) begin
          tk = pool_pat[k][pool_cnt[k] % pool_len[k]] ^ ($urandom_range(0, 19) == 0);
          pool_cnt[k]++;
          issue_request(OP_TRAIN, pool_addr[k], tk);
        end else if (r < 90) begin
          issue_request(OP_PREDICT, pool_addr[k], 1'b0);
        end else begin
          issue_request(op_e'($urandom_range(0, 1)), $urandom, 1'($urandom_range(0, 1)));
        end
        if ($urandom_range(0, 99) < idle_pct) idle_burst();
      end
    end

    // Wait for the last predictions, then a little longer for stray strobes.
    start_i <= 1'b0;
    guard = 0;
    while (expected_predictions.size() != 0 && guard < 200) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (expected_predictions.size() != 0) begin
      report_mismatch($sformatf("%0d predictions never arrived", expected_predictions.size()));
    end

    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
